// ----- rtl/indexed_sequence_store_defines.svh -----
// Assertion macros for the indexed sequence store.
// Used by the top level; expects clk and rst_n in scope.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed sequence store check failed");

// The consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed sequence store check failed");

`endif

// ----- rtl/iss_pkg.sv -----
// Shared constants, command and status codes, and structs for the
// indexed sequence store. No dependencies.
package iss_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [LEN_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
    logic [LEN_W-1:0]         erase_count;
  } iss_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         list_length;
    logic [STAT_W-1:0]        status;
  } iss_res_t;

endpackage

// ----- rtl/iss_engine.sv -----
// Command sequencer and entry memory of the indexed sequence store.
// Moves one entry per cycle through a single read and write port.
// Depends on iss_pkg.
module iss_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  iss_pkg::iss_cmd_t  cmd_in,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_take,
  output iss_pkg::iss_res_t  res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MOVE   = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]                       state_r, state_nxt;
  iss_pkg::iss_cmd_t                cmd_r, cmd_nxt;
  logic [iss_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [iss_pkg::LEN_W-1:0]        newlen_r, newlen_nxt;
  logic [iss_pkg::STAT_W-1:0]       status_r, status_nxt;
  logic                             up_r, up_nxt;
  logic [iss_pkg::ADDR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [iss_pkg::ADDR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [iss_pkg::LEN_W-1:0]        cnt_r, cnt_nxt;
  logic                             pend_r, pend_nxt;
  logic [iss_pkg::ADDR_W-1:0]       pend_addr_r, pend_addr_nxt;
  logic signed [iss_pkg::DATA_W-1:0] rd_data_r;

  logic signed [iss_pkg::DATA_W-1:0] mem [iss_pkg::DEPTH];

  logic                              mem_re;
  logic [iss_pkg::ADDR_W-1:0]        mem_ra;
  logic                              mem_we;
  logic [iss_pkg::ADDR_W-1:0]        mem_wa;
  logic signed [iss_pkg::DATA_W-1:0] mem_wd;

  logic [iss_pkg::LEN_W-1:0] avail;
  logic [iss_pkg::LEN_W-1:0] n_erase;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_comb begin
    avail   = len_r - cmd_r.position;
    n_erase = (cmd_r.erase_count < avail) ? cmd_r.erase_count : avail;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    newlen_nxt    = newlen_r;
    status_nxt    = status_r;
    up_nxt        = up_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    mem_re        = 1'b0;
    mem_ra        = rd_ptr_r;
    mem_we        = pend_r;
    mem_wa        = pend_addr_r;
    mem_wd        = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd_in;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt = iss_pkg::ST_DONE;
        newlen_nxt = len_r;
        cnt_nxt    = '0;
        up_nxt     = 1'b0;
        rd_ptr_nxt = iss_pkg::ADDR_W'(len_r - 1'b1);
        wr_ptr_nxt = iss_pkg::ADDR_W'(len_r);
        unique case (cmd_r.cmd)
          iss_pkg::CMD_INSERT: begin
            if (cmd_r.position > len_r) begin
              status_nxt = iss_pkg::ST_RANGE;
            end else if (len_r >= iss_pkg::DEPTH_LEN) begin
              status_nxt = iss_pkg::ST_FULL;
            end else begin
              // Entries from the end down to the position each move up by one.
              cnt_nxt    = avail;
              newlen_nxt = len_r + 1'b1;
            end
          end
          iss_pkg::CMD_ERASE: begin
            if ((cmd_r.position >= len_r) || (cmd_r.erase_count == '0)) begin
              status_nxt = iss_pkg::ST_RANGE;
            end else begin
              // The tail beyond the erased run moves down to the position.
              up_nxt     = 1'b1;
              cnt_nxt    = avail - n_erase;
              rd_ptr_nxt = iss_pkg::ADDR_W'(cmd_r.position + n_erase);
              wr_ptr_nxt = iss_pkg::ADDR_W'(cmd_r.position);
              newlen_nxt = len_r - n_erase;
            end
          end
          default: begin
            if (cmd_r.position >= len_r) begin
              status_nxt = iss_pkg::ST_RANGE;
            end
          end
        endcase
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        if (cnt_r != '0) begin
          mem_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = wr_ptr_r;
          cnt_nxt       = cnt_r - 1'b1;
          if (up_r) begin
            rd_ptr_nxt = rd_ptr_r + 1'b1;
            wr_ptr_nxt = wr_ptr_r + 1'b1;
          end else begin
            rd_ptr_nxt = rd_ptr_r - 1'b1;
            wr_ptr_nxt = wr_ptr_r - 1'b1;
          end
        end else if (!pend_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (status_r == iss_pkg::ST_DONE) begin
          if ((cmd_r.cmd == iss_pkg::CMD_INSERT) || (cmd_r.cmd == iss_pkg::CMD_SET)) begin
            mem_we = 1'b1;
            mem_wa = iss_pkg::ADDR_W'(cmd_r.position);
            mem_wd = cmd_r.item_value;
          end
          if (cmd_r.cmd == iss_pkg::CMD_GET) begin
            mem_re = 1'b1;
            mem_ra = iss_pkg::ADDR_W'(cmd_r.position);
          end
        end
        len_nxt   = newlen_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    newlen_r    <= newlen_nxt;
    status_r    <= status_nxt;
    up_r        <= up_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    wr_ptr_r    <= wr_ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);

  always_comb begin
    res.read_value  = ((cmd_r.cmd == iss_pkg::CMD_GET) && (status_r == iss_pkg::ST_DONE)) ?
                      rd_data_r : '0;
    res.list_length = len_r;
    res.status      = status_r;
  end

endmodule

// ----- rtl/indexed_sequence_store.sv -----
// Indexed sequence store: holds an ordered list of up to 256 signed 32-bit
// entries and executes insert, erase, get and set commands, one item at a
// time, each giving one result with the list length after the command.
// Insert moves length minus position entries, erase moves the entries
// behind the erased run, get and set move none. The entry memory moves one
// entry per cycle through one read and one write port. A new item is taken
// once the previous result has passed into the output register, where it
// may still wait.
// Depends on iss_pkg, iss_engine and indexed_sequence_store_defines.svh.
`include "indexed_sequence_store_defines.svh"

module indexed_sequence_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [iss_pkg::CMD_W-1:0]           in_cmd,
  input  logic [iss_pkg::LEN_W-1:0]           in_position,
  input  logic signed [iss_pkg::DATA_W-1:0]   in_item_value,
  input  logic [iss_pkg::LEN_W-1:0]           in_erase_count,
  input  logic                                in_batch_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [iss_pkg::DATA_W-1:0]   out_read_value,
  output logic [iss_pkg::LEN_W-1:0]           out_list_length,
  output logic [iss_pkg::STAT_W-1:0]          out_status
);

  iss_pkg::iss_cmd_t cmd_in;
  iss_pkg::iss_res_t eng_res;
  iss_pkg::iss_res_t res_r;
  logic              eng_idle;
  logic              eng_valid;
  logic              res_take;
  logic              start;
  logic              out_valid_r, out_valid_nxt;

  // The batch marker carries no meaning for storage; every insert stands alone.
  always_comb begin
    cmd_in.cmd         = in_cmd;
    cmd_in.position    = in_position;
    cmd_in.item_value  = in_item_value;
    cmd_in.erase_count = in_erase_count ^ {iss_pkg::LEN_W{in_batch_last & 1'b0}};
  end

  assign start    = in_valid && eng_idle;
  assign in_stall = !eng_idle;
  assign res_take = eng_valid && (!out_valid_r || !out_stall);

  iss_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd_in    (cmd_in),
    .idle      (eng_idle),
    .res_valid (eng_valid),
    .res_take  (res_take),
    .res       (eng_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      res_r <= eng_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = res_r.read_value;
  assign out_list_length = res_r.list_length;
  assign out_status      = res_r.status;

  `ISS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `ISS_ASSERT_SAME(a_full_at_depth, out_valid && (out_status == iss_pkg::ST_FULL), out_list_length == iss_pkg::DEPTH_LEN)
  `ISS_ASSERT_SAME(a_read_only_when_done, out_valid && (out_read_value != '0), out_status == iss_pkg::ST_DONE)
  `ISS_ASSERT_SAME(a_length_bounded, out_valid, out_list_length <= iss_pkg::DEPTH_LEN)

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for indexed_sequence_store: random and directed list commands,
// each result checked against an in-bench list model.
// Depends on iss_pkg and the indexed_sequence_store top level.
module tb;
  import iss_pkg::*;

  localparam int ITEM_TARGET = 1930;
  localparam int CYCLE_LIMIT = 2500000;
  localparam int TAIL_CYCLES = 300;
  localparam int CALM_ITEMS  = 150;
  localparam int LONG_HOLD   = 500;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [LEN_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
    logic [LEN_W-1:0]         erase_count;
    logic                     batch_last;
    logic                     drain;
  } list_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_cmd = CMD_GET;
  logic [LEN_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic [LEN_W-1:0]         in_erase_count = '0;
  logic                     in_batch_last = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic [LEN_W-1:0]         out_list_length;
  logic [STAT_W-1:0]        out_status;

  list_cmd_t pending_cmds[$];
  iss_res_t  expected_results[$];

  // List model state.
  logic signed [DATA_W-1:0] model_mem [0:DEPTH-1];
  int model_len = 0;
  int peak_len = 0;

  int gen_len = 0;
  int useful_items = 0;
  bit drain_next = 1'b0;
  int total_items = 0;
  int sent_count = 0;
  int recv_count = 0;
  int errors = 0;
  int cycle_count = 0;
  int done_seen = 0;
  int range_seen = 0;
  int full_seen = 0;
  int idle_left = 0;
  int stall_left = 0;
  bit long_hold_done = 1'b0;

  indexed_sequence_store i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .in_erase_count (in_erase_count),
    .in_batch_last  (in_batch_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_list_length(out_list_length),
    .out_status     (out_status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Applies one command to the list model and returns the result it must give.
  function automatic iss_res_t list_apply(input list_cmd_t c);
    iss_res_t r;
    int i;
    int n;
    r.read_value  = '0;
    r.status      = ST_DONE;
    case (c.cmd)
      CMD_INSERT: begin
        if (int'(c.position) > model_len) begin
          r.status = ST_RANGE;
        end else if (model_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = model_len; i > int'(c.position); i--) model_mem[i] = model_mem[i-1];
          model_mem[c.position] = c.item_value;
          model_len++;
        end
      end
      CMD_ERASE: begin
        if (int'(c.position) >= model_len || c.erase_count == '0) begin
          r.status = ST_RANGE;
        end else begin
          n = model_len - int'(c.position);
          if (int'(c.erase_count) < n) n = int'(c.erase_count);
          for (i = int'(c.position); i + n < model_len; i++) model_mem[i] = model_mem[i+n];
          model_len -= n;
        end
      end
      CMD_GET: begin
        if (int'(c.position) >= model_len) r.status = ST_RANGE;
        else r.read_value = model_mem[c.position];
      end
      default: begin
        if (int'(c.position) >= model_len) r.status = ST_RANGE;
        else model_mem[c.position] = c.item_value;
      end
    endcase
    if (model_len > peak_len) peak_len = model_len;
    r.list_length = LEN_W'(model_len);
    return r;
  endfunction

  // Length the list will have after a command; keeps the generator in step.
  function automatic int length_after(input logic [CMD_W-1:0] cmd, input int pos,
                                      input int cnt, input int len);
    int n;
    if (cmd == CMD_INSERT && pos <= len && len < DEPTH) return len + 1;
    if (cmd == CMD_ERASE && pos < len && cnt != 0) begin
      n = len - pos;
      if (cnt < n) n = cnt;
      return len - n;
    end
    return len;
  endfunction

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                         input logic [DATA_W-1:0] val, input int cnt,
                         input bit last, input bit counts);
    list_cmd_t c;
    c.cmd         = cmd;
    c.position    = LEN_W'(pos);
    c.item_value  = val;
    c.erase_count = LEN_W'(cnt);
    c.batch_last  = last;
    c.drain       = drain_next;
    drain_next    = 1'b0;
    pending_cmds.push_back(c);
    gen_len = length_after(cmd, pos & 9'h1ff, cnt & 9'h1ff, gen_len);
    if (counts) useful_items++;
  endtask

  task automatic add_erase_run();
    int pos;
    int cnt;
    pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
    cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 511) : $urandom_range(1, 4);
    add_cmd(CMD_ERASE, pos, $urandom, cnt, 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Fills the list, probes inserts into the full list, then its last entry.
  task automatic add_fill();
    while (gen_len < DEPTH)
      add_cmd(CMD_INSERT, $urandom_range(0, gen_len), $urandom, $urandom_range(0, 511),
              gen_len == DEPTH - 1, 1'b1);
    add_cmd(CMD_INSERT, DEPTH, $urandom, 0, 1'b1, 1'b1);
    add_cmd(CMD_INSERT, $urandom_range(DEPTH + 1, 511), $urandom, 0, 1'b0, 1'b1);
    add_cmd(CMD_INSERT, $urandom_range(0, DEPTH - 1), $urandom, 0, 1'b1, 1'b1);
    add_cmd(CMD_GET, DEPTH - 1, $urandom, 0, 1'b0, 1'b1);
    add_cmd(CMD_SET, DEPTH - 1, $urandom, 0, 1'b0, 1'b1);
    add_cmd(CMD_GET, DEPTH - 1, $urandom, 0, 1'b0, 1'b1);
    add_cmd(CMD_ERASE, DEPTH - 1, $urandom, 1, 1'b0, 1'b1);
  endtask

  initial begin
    int pick;
    int n;
    int k;
    int p;
    int fills_done;
    int next_drain;

    // Directed: empty-list corner cases, value extremes, erase past the end.
    add_cmd(CMD_GET,    0,   32'h0,        0,   1'b0, 1'b1);
    add_cmd(CMD_ERASE,  0,   32'h0,        1,   1'b0, 1'b1);
    add_cmd(CMD_SET,    0,   32'h5,        0,   1'b0, 1'b1);
    add_cmd(CMD_INSERT, 1,   32'h1,        0,   1'b0, 1'b1);
    add_cmd(CMD_ERASE,  0,   32'h0,        0,   1'b0, 1'b1);
    add_cmd(CMD_INSERT, 0,   32'h7fffffff, 0,   1'b0, 1'b1);
    add_cmd(CMD_INSERT, 0,   32'h80000000, 0,   1'b0, 1'b1);
    add_cmd(CMD_INSERT, 2,   32'hffffffff, 0,   1'b0, 1'b1);
    add_cmd(CMD_INSERT, 1,   32'h0,        0,   1'b1, 1'b1);
    for (k = 0; k < 4; k++) add_cmd(CMD_GET, k, 32'h0, 0, 1'b0, 1'b1);
    add_cmd(CMD_GET,    4,   32'h0,        0,   1'b0, 1'b1);
    add_cmd(CMD_GET,    511, 32'hffffffff, 511, 1'b1, 1'b1);
    add_cmd(CMD_SET,    3,   32'h55555555, 0,   1'b0, 1'b1);
    add_cmd(CMD_SET,    4,   32'h12345678, 0,   1'b0, 1'b1);
    add_cmd(CMD_GET,    3,   32'h0,        0,   1'b0, 1'b1);
    add_cmd(CMD_ERASE,  1,   32'h0,        0,   1'b0, 1'b1);
    add_cmd(CMD_ERASE,  511, 32'h0,        1,   1'b0, 1'b1);
    add_cmd(CMD_ERASE,  1,   32'h0,        511, 1'b0, 1'b1);
    add_cmd(CMD_GET,    0,   32'h0,        0,   1'b0, 1'b1);
    add_cmd(CMD_ERASE,  0,   32'h0,        1,   1'b0, 1'b1);
    add_cmd(CMD_INSERT, 256, 32'haaaaaaaa, 0,   1'b1, 1'b1);

    // Random: mostly well-formed batches and in-range accesses, some noise.
    fills_done = 0;
    next_drain = useful_items;
    while (useful_items < ITEM_TARGET) begin
      if (useful_items >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 450;
      end
      pick = $urandom_range(0, 99);
      if ((pick < 3 && fills_done < 3) || (fills_done == 0 && useful_items > 300)) begin
        add_fill();
        fills_done++;
      end else if (pick < 32) begin
        if (gen_len > 200) begin
          add_erase_run();
        end else begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          p = $urandom_range(0, gen_len);
          for (k = 0; k < n; k++)
            add_cmd(CMD_INSERT, p + k, $urandom, $urandom_range(0, 511), k == n - 1, 1'b1);
        end
      end else if (pick < 50) begin
        add_erase_run();
      end else if (pick < 72) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          add_cmd(CMD_GET, (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0, $urandom,
                  $urandom_range(0, 511), 1'($urandom_range(0, 1)), 1'b1);
      end else if (pick < 88) begin
        add_cmd(CMD_SET, (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0, $urandom,
                $urandom_range(0, 511), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        add_cmd(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 511), $urandom,
                $urandom_range(0, 511), 1'($urandom_range(0, 1)), 1'b0);
      end
    end
    total_items = pending_cmds.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < total_items || recv_count < sent_count) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("Checked %0d results: %0d done, %0d out of range, %0d store full.",
             recv_count, done_seen, range_seen, full_seen);
    $display("Longest list reached %0d of %0d entries; %0d errors.", peak_len, DEPTH, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Driver: presents the oldest pending item and predicts its result on acceptance.
  always @(posedge clk) begin
    bit took;
    bit idling_on;
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      took = in_valid && !in_stall;
      idling_on = (sent_count < total_items - CALM_ITEMS) && ((sent_count / 64) % 3 != 2);
      if (took) begin
        expected_results.push_back(list_apply(pending_cmds.pop_front()));
        sent_count <= sent_count + 1;
        if (idling_on && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 3);
      end
      if (!in_valid || took) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && sent_count + took != recv_count)) begin
          in_valid       <= 1'b1;
          in_cmd         <= pending_cmds[0].cmd;
          in_position    <= pending_cmds[0].position;
          in_item_value  <= pending_cmds[0].item_value;
          in_erase_count <= pending_cmds[0].erase_count;
          in_batch_last  <= pending_cmds[0].batch_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: short random bursts, plus one long hold that backs up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        if (!long_hold_done && recv_count >= 600) begin
          stall_left = LONG_HOLD;
          long_hold_done = 1'b1;
        end else if (recv_count < total_items - CALM_ITEMS && (recv_count / 80) % 3 != 2 &&
                     $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 3);
        end
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    iss_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      recv_count <= recv_count + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d length %0d status %0d",
                 $time, out_read_value, out_list_length, out_status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        case (want.status)
          ST_DONE:  done_seen++;
          ST_RANGE: range_seen++;
          default:  full_seen++;
        endcase
        if (out_read_value !== want.read_value) begin
          $display("%0t: read_value mismatch, expected %0d, got %0d",
                   $time, want.read_value, out_read_value);
          errors++;
        end
        if (out_list_length !== want.list_length) begin
          $display("%0t: list_length mismatch, expected %0d, got %0d",
                   $time, want.list_length, out_list_length);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("FAIL");
      $finish;
    end
  end

endmodule
